[sv/nkc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkc_pkg: shared types and constants of the nucleotide k-mer counter
// Holds the channel payloads, the command passed from front to back, and the
// operation, index and character codes.
// ----------------------------------------------------------------------------
package nkc_pkg;

  localparam int VALUE_W = 48;
  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

  // operation codes of an input item
  localparam logic [1:0] OP_BASE = 2'd0;
  localparam logic [1:0] OP_END  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // result kinds
  localparam logic KIND_LEN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // counter index map
  localparam logic [6:0] IDX_DI_BASE  = 7'd4;
  localparam logic [6:0] IDX_TRI_BASE = 7'd20;
  localparam logic [6:0] IDX_TRI_END  = 7'd84;
  localparam logic [6:0] IDX_SEG      = 7'd84;
  localparam logic [6:0] IDX_BASES    = 7'd85;

  localparam logic [7:0] CHAR_N_UPPER = 8'h4e;
  localparam logic [7:0] CHAR_N_LOWER = 8'h6e;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_MONO,
    SEL_DI,
    SEL_TRI,
    SEL_SEG,
    SEL_BASES,
    SEL_ZERO
  } rd_sel_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] base_char;
    logic [6:0] counter_index;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic [VALUE_W-1:0] result_value;
  } out_t;

  typedef struct packed {
    logic               mono_inc;
    logic               di_inc;
    logic               tri_inc;
    logic [1:0]         mono_addr;
    logic [3:0]         di_addr;
    logic [5:0]         tri_addr;
    logic               seg_close;
    logic [VALUE_W-1:0] seg_len;
    rd_sel_t            rd_sel;
  } cmd_t;

endpackage
`default_nettype wire

[sv/nkc_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkc_fifo: small register-based first-in first-out queue
// Power-of-two depth, combinational head read, occupancy count.
// ----------------------------------------------------------------------------
module nkc_fifo #(
  parameter int W  = 8,
  parameter int AW = 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  input  wire logic         rd_en,
  output logic      [W-1:0] rd_data,
  output logic              full,
  output logic              empty,
  output logic      [AW:0]  count
);

  localparam int DEPTH = 2 ** AW;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  assign rd_data = mem_r[rd_ptr_r];
  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (AW)'(wr_en);
    rd_ptr_nxt = rd_ptr_r + (AW)'(rd_en);
    count_nxt  = count_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[sv/nkc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkc_front: item classifier
// Tracks sequence position, the last two bases and the open segment length,
// and turns accepted items into counter commands for the back end.
// ----------------------------------------------------------------------------
module nkc_front
  import nkc_pkg::*;
#(
  parameter int LW = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data,
  input  wire logic accept,
  input  wire in_t  item,
  output logic      cmd_push,
  output cmd_t      cmd
);

  logic          split_r, split_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [3:0]    last2_r, last2_nxt;
  logic [LW-1:0] run_r, run_nxt;

  logic [1:0] code;
  logic [5:0] mer;
  logic       is_n;
  logic [6:0] di_off;
  logic [6:0] tri_off;

  always_comb begin
    code    = item.base_char[2:1];
    mer     = {last2_r, code};
    is_n    = (item.base_char == CHAR_N_UPPER) || (item.base_char == CHAR_N_LOWER);
    di_off  = item.counter_index - IDX_DI_BASE;
    tri_off = item.counter_index - IDX_TRI_BASE;

    split_nxt = cfg_wr_en ? cfg_wr_data : split_r;
    phase_nxt = phase_r;
    last2_nxt = last2_r;
    run_nxt   = run_r;

    cmd        = '0;
    cmd.rd_sel = SEL_NONE;
    cmd_push   = 1'b0;

    if (accept) begin
      unique case (item.operation)
        OP_BASE: begin
          cmd_push      = 1'b1;
          cmd.mono_inc  = 1'b1;
          cmd.mono_addr = code;
          cmd.di_inc    = (phase_r >= 2'd1);
          cmd.di_addr   = mer[3:0];
          cmd.tri_inc   = (phase_r >= 2'd2);
          cmd.tri_addr  = mer;
          if (phase_r < 2'd2) begin
            phase_nxt = phase_r + 2'd1;
          end
          last2_nxt = mer[3:0];
          if (split_r && is_n) begin
            // an N closes a non-empty segment and is not part of it
            if (run_r != '0) begin
              cmd.seg_close = 1'b1;
              cmd.seg_len   = VALUE_W'(run_r);
              run_nxt       = '0;
            end
          end else if (run_r != '1) begin
            run_nxt = run_r + 1'b1;
          end
        end
        OP_END: begin
          phase_nxt = 2'd0;
          if (!split_r || (run_r != '0)) begin
            cmd_push      = 1'b1;
            cmd.seg_close = 1'b1;
            cmd.seg_len   = VALUE_W'(run_r);
            run_nxt       = '0;
          end
        end
        OP_READ: begin
          cmd_push      = 1'b1;
          cmd.mono_addr = item.counter_index[1:0];
          cmd.di_addr   = di_off[3:0];
          cmd.tri_addr  = tri_off[5:0];
          if (item.counter_index < IDX_DI_BASE) begin
            cmd.rd_sel = SEL_MONO;
          end else if (item.counter_index < IDX_TRI_BASE) begin
            cmd.rd_sel = SEL_DI;
          end else if (item.counter_index < IDX_TRI_END) begin
            cmd.rd_sel = SEL_TRI;
          end else if (item.counter_index == IDX_SEG) begin
            cmd.rd_sel = SEL_SEG;
          end else if (item.counter_index == IDX_BASES) begin
            cmd.rd_sel = SEL_BASES;
          end else begin
            cmd.rd_sel = SEL_ZERO;
          end
        end
        default: begin
          // unused operation code: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r <= 1'b0;
      phase_r <= '0;
      last2_r <= '0;
      run_r   <= '0;
    end else begin
      split_r <= split_nxt;
      phase_r <= phase_nxt;
      last2_r <= last2_nxt;
      run_r   <= run_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/nkc_cnt_bank.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkc_cnt_bank: one bank of saturating counters
// Registered read, increment and write back in the following cycle, with a bypass
// of the last write and per-entry valid bits so that reset reads as zero.
// ----------------------------------------------------------------------------
module nkc_cnt_bank #(
  parameter int AW = 2,
  parameter int CW = 48
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          inc,
  output logic      [CW-1:0] cur_val
);

  localparam int DEPTH = 2 ** AW;

  logic [CW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [CW-1:0]    q_r;
  logic             qv_r;
  logic [AW-1:0]    addr_r;
  logic             inc_r;
  logic             wb_vld_r;
  logic [AW-1:0]    wb_addr_r;
  logic [CW-1:0]    wb_data_r;
  logic [CW-1:0]    upd_nxt;

  always_comb begin
    // take the value written at the same edge as the read
    if (wb_vld_r && (wb_addr_r == addr_r)) begin
      cur_val = wb_data_r;
    end else if (qv_r) begin
      cur_val = q_r;
    end else begin
      cur_val = '0;
    end
    upd_nxt = (cur_val == '1) ? cur_val : cur_val + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r    <= mem[rd_addr];
      addr_r <= rd_addr;
    end
    if (inc_r) begin
      mem[addr_r] <= upd_nxt;
      wb_addr_r   <= addr_r;
      wb_data_r   <= upd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      qv_r     <= 1'b0;
      inc_r    <= 1'b0;
      wb_vld_r <= 1'b0;
    end else begin
      inc_r <= rd_en & inc;
      if (rd_en) begin
        qv_r <= vld_r[rd_addr];
      end
      if (inc_r) begin
        vld_r[addr_r] <= 1'b1;
        wb_vld_r      <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/nkc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nkc_back: counter update and read-out
// Pops commands, updates the three k-mer banks and the segment and base
// totals, and pushes segment lengths and read data into the result queue.
// ----------------------------------------------------------------------------
module nkc_back
  import nkc_pkg::*;
#(
  parameter int CW     = 48,
  parameter int OUT_AW = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_empty,
  input  wire cmd_t          cmd,
  output logic               cmd_pop,
  input  wire logic [OUT_AW:0] out_count,
  output logic               out_push,
  output out_t               out_res
);

  localparam int OUT_DEPTH = 2 ** OUT_AW;
  localparam logic [CW-1:0] CNT_MAX = '1;

  logic          s2_vld_r;
  cmd_t          s2_cmd_r;
  logic          s2_produce;
  logic [CW-1:0] mono_cur, di_cur, tri_cur;
  logic [CW-1:0] seg_total_r, seg_total_nxt;
  logic [CW-1:0] base_total_r, base_total_nxt;
  logic [64:0]   base_sum;

  function automatic logic [VALUE_W-1:0] clip_val(input logic [CW-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return (ext > 64'(VALUE_MAX)) ? VALUE_MAX : ext[VALUE_W-1:0];
  endfunction

  assign s2_produce = s2_cmd_r.seg_close || (s2_cmd_r.rd_sel != SEL_NONE);

  // pop only when the result queue has room for the item in flight and this one
  assign cmd_pop = !cmd_empty &&
                   ((int'(out_count) + int'(s2_vld_r && s2_produce)) < OUT_DEPTH);

  nkc_cnt_bank #(.AW(2), .CW(CW)) u_mono (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (cmd_pop),
    .rd_addr (cmd.mono_addr),
    .inc     (cmd.mono_inc),
    .cur_val (mono_cur)
  );

  nkc_cnt_bank #(.AW(4), .CW(CW)) u_di (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (cmd_pop),
    .rd_addr (cmd.di_addr),
    .inc     (cmd.di_inc),
    .cur_val (di_cur)
  );

  nkc_cnt_bank #(.AW(6), .CW(CW)) u_tri (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (cmd_pop),
    .rd_addr (cmd.tri_addr),
    .inc     (cmd.tri_inc),
    .cur_val (tri_cur)
  );

  always_comb begin
    base_sum       = 65'(base_total_r) + 65'(s2_cmd_r.seg_len);
    seg_total_nxt  = seg_total_r;
    base_total_nxt = base_total_r;
    if (s2_vld_r && s2_cmd_r.seg_close) begin
      seg_total_nxt  = (seg_total_r == CNT_MAX) ? CNT_MAX : seg_total_r + 1'b1;
      base_total_nxt = (base_sum > 65'(CNT_MAX)) ? CNT_MAX : base_sum[CW-1:0];
    end

    out_push = s2_vld_r && s2_produce;
    out_res  = '0;
    if (s2_cmd_r.seg_close) begin
      out_res.result_kind  = KIND_LEN;
      out_res.result_value = s2_cmd_r.seg_len;
    end else begin
      out_res.result_kind = KIND_READ;
      case (s2_cmd_r.rd_sel)
        SEL_MONO:  out_res.result_value = clip_val(mono_cur);
        SEL_DI:    out_res.result_value = clip_val(di_cur);
        SEL_TRI:   out_res.result_value = clip_val(tri_cur);
        SEL_SEG:   out_res.result_value = clip_val(seg_total_r);
        SEL_BASES: out_res.result_value = clip_val(base_total_r);
        default:   out_res.result_value = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s2_cmd_r <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r     <= 1'b0;
      seg_total_r  <= '0;
      base_total_r <= '0;
    end else begin
      s2_vld_r     <= cmd_pop;
      seg_total_r  <= seg_total_nxt;
      base_total_r <= base_total_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/nucleotide_kmer_counter.sv]
// A result passes the command queue, the back-end stage and the result queue.
// Throughput: one item per cycle while the command queue has room; a base updates
//   the mono, di (from 2nd base) and tri (from 3rd base) banks by read and write back.
// Input stalls only when the two-entry command queue fills as the result queue backs up.
// Reset (rst_n low, synchronous) clears all counters, totals and queues at once;
//   counter banks use per-entry valid bits, so no clearing pass follows.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nucleotide_kmer_counter: mono-, di- and trinucleotide frequency counter
// Counts k-mers of a DNA base stream for k = 1..3 in saturating counters,
// splits sequences into segments and reports segment lengths and counters.
// ----------------------------------------------------------------------------
module nucleotide_kmer_counter
  import nkc_pkg::*;
#(
  parameter int COUNT_WIDTH  = 48,
  parameter int LENGTH_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // input channel
  input  wire logic push,
  output logic      full,
  input  wire in_t  in_data,
  // result channel
  output logic      empty,
  input  wire logic pop,
  output out_t      out_data,
  // configuration
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data
);

  // queue sizes between the pipeline parts
  localparam int CMD_AW = 1;
  localparam int OUT_AW = 2;

  logic          in_xfer;
  logic          cmd_push;
  cmd_t          cmd_in;
  cmd_t          cmd_head;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          res_push;
  out_t          res_in;
  logic [OUT_AW:0] res_count;

  // an input transfer completes when an item is offered and the command queue has room
  assign in_xfer = push && !full;
  assign full    = cmd_full;

  // front end: classify the item, track position and open segment
  nkc_front #(.LW(LENGTH_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (in_xfer),
    .item        (in_data),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in)
  );

  // decouple the classifier from the counter pipeline
  nkc_fifo #(.W($bits(cmd_t)), .AW(CMD_AW)) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .full    (cmd_full),
    .empty   (cmd_empty),
    .count   ()
  );

  // back end: counter banks, totals and read-out
  nkc_back #(.CW(COUNT_WIDTH), .OUT_AW(OUT_AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_count (res_count),
    .out_push  (res_push),
    .out_res   (res_in)
  );

  // hold finished results until the consumer takes them
  nkc_fifo #(.W($bits(out_t)), .AW(OUT_AW)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .rd_en   (pop && !empty),
    .rd_data (out_data),
    .full    (),
    .empty   (empty),
    .count   (res_count)
  );

endmodule
`default_nettype wire

[bench/nucleotide_kmer_counter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nucleotide_kmer_counter_test: self-checking bench for the k-mer counter
// Streams base characters, sequence ends and counter reads through the input
// queue port. A behavioral copy of the counter banks predicts every segment
// length and read result, and the bench checks each result transfer against it
// under random idling on both sides and with the split mode in both settings.
// ----------------------------------------------------------------------------
module nucleotide_kmer_counter_test;
  import nkc_pkg::*;

  localparam int RUN_W       = 32;    // segment length register width
  localparam int PHASE_ITEMS = 400;   // random items per mode setting
  localparam int IDLE_LIMIT  = 4000;  // cycles without any transfer
  localparam int LONG_HOLD   = 500;   // receiver hold-off to back up the input
  localparam logic [1:0] OP_IDLE = 2'd3;  // unused operation, ignored by the block

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t  in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  nucleotide_kmer_counter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the counter state. Everything starts from reset values.
  // --------------------------------------------------------------------------
  bit                 split_mode = 1'b0;
  logic [3:0]         prev_codes = '0;   // codes of the two previous bases
  logic [1:0]         seq_phase = '0;    // 0, 1 or 2+ bases seen in this sequence
  logic [VALUE_W-1:0] mono_cnt [4]  = '{default: '0};
  logic [VALUE_W-1:0] di_cnt   [16] = '{default: '0};
  logic [VALUE_W-1:0] tri_cnt  [64] = '{default: '0};
  logic [VALUE_W-1:0] seg_total = '0;
  logic [VALUE_W-1:0] base_total = '0;
  logic [RUN_W-1:0]   run_len = '0;

  in_t  base_stream [$];   // items waiting to be offered on the input port
  out_t due_reports [$];   // segment lengths and read data not yet seen

  int mismatch_count = 0;
  int reports_taken = 0;

  function automatic logic [VALUE_W-1:0] sat_inc(logic [VALUE_W-1:0] x);
    return (x == VALUE_MAX) ? x : x + 1'b1;
  endfunction

  // Close the open segment: report its length, fold it into the totals.
  task automatic finish_segment();
    logic [VALUE_W:0] sum;
    due_reports.insert(due_reports.size(), out_t'{KIND_LEN, VALUE_W'(run_len)});
    seg_total = sat_inc(seg_total);
    sum = {1'b0, base_total} + run_len;
    base_total = sum[VALUE_W] ? VALUE_MAX : sum[VALUE_W-1:0];
    run_len = '0;
  endtask

  // Apply one accepted item to the counter copy and queue what it reports.
  task automatic tally_item(input in_t item);
    logic [1:0]         code;
    logic [5:0]         mer;
    bit                 is_n;
    logic [6:0]         idx;
    logic [VALUE_W-1:0] v;
    case (item.operation)
      OP_BASE: begin
        // A=0, C=1, T=2, G=3; N folds onto G
        code = item.base_char[2:1];
        mer = {prev_codes, code};
        is_n = (item.base_char == CHAR_N_UPPER) || (item.base_char == CHAR_N_LOWER);
        mono_cnt[code] = sat_inc(mono_cnt[code]);
        if (seq_phase >= 2'd1) di_cnt[mer[3:0]] = sat_inc(di_cnt[mer[3:0]]);
        if (seq_phase >= 2'd2) tri_cnt[mer] = sat_inc(tri_cnt[mer]);
        if (seq_phase < 2'd2) seq_phase = seq_phase + 1'b1;
        prev_codes = mer[3:0];
        if (split_mode && is_n) begin
          // an N only ends a segment that holds bases
          if (run_len != '0) finish_segment();
        end else if (run_len != '1) begin
          run_len = run_len + 1'b1;
        end
      end
      OP_END: begin
        seq_phase = '0;
        if (!split_mode || run_len != '0) finish_segment();
      end
      OP_READ: begin
        idx = item.counter_index;
        if (idx < IDX_DI_BASE) v = mono_cnt[idx[1:0]];
        else if (idx < IDX_TRI_BASE) v = di_cnt[4'(idx - IDX_DI_BASE)];
        else if (idx < IDX_TRI_END) v = tri_cnt[6'(idx - IDX_TRI_BASE)];
        else if (idx == IDX_SEG) v = seg_total;
        else if (idx == IDX_BASES) v = base_total;
        else v = '0;
        due_reports.insert(due_reports.size(), out_t'{KIND_READ, v});
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer items from base_stream, hold an item until its transfer,
  // then wait a drawn number of cycles before the next one. Bursts with no
  // gaps come and go at random.
  // --------------------------------------------------------------------------
  int send_gap = 0;
  bit send_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) tally_item(in_data);
      // hold the offered item while the block is full
      if (!push || !full) begin
        if (send_gap > 0) begin
          push <= 1'b0;
          send_gap--;
        end else if (base_stream.size() > 0) begin
          in_data <= base_stream.pop_front();
          push <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 9);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result transfer against the oldest prediction and
  // draw a stall after it. Once, early in the random part, hold pop low for a
  // long stretch so the result queue fills and the input stalls.
  // --------------------------------------------------------------------------
  int recv_stall = 0;
  int long_hold = 0;
  bit recv_burst = 1'b0;

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_reports.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with nothing pending, got kind %0d value %0d",
                   $time, out_data.result_kind, out_data.result_value);
        end else begin
          want = due_reports.pop_front();
          if (out_data.result_kind !== want.result_kind) begin
            mismatch_count++;
            $display("%0t: result_kind expected %0d, got %0d",
                     $time, want.result_kind, out_data.result_kind);
          end
          if (out_data.result_value !== want.result_value) begin
            mismatch_count++;
            $display("%0t: result_value expected %0d, got %0d",
                     $time, want.result_value, out_data.result_value);
          end
        end
        reports_taken++;
        if (reports_taken == 60) long_hold = LONG_HOLD;
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if (long_hold > 0) begin
        pop <= 1'b0;
        long_hold--;
      end else if (recv_stall > 0) begin
        pop <= 1'b0;
        recv_stall--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if neither side transfers for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_item(logic [1:0] op, logic [7:0] ch, logic [6:0] idx);
    base_stream.insert(base_stream.size(), in_t'{op, ch, idx});
  endfunction

  // Wait until every item is taken and every result has come out, then let
  // the pipeline drain past any item that reports nothing.
  task automatic settle();
    while (base_stream.size() != 0 || push || due_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_split(input bit v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    split_mode = v;
  endtask

  // Mostly well-formed sequences over ACGTN in both cases, with reads mixed
  // in; the rest is stray reads, odd bytes, missing ends and unused ops.
  task automatic queue_random_phase(input int count);
    string alphabet;
    int    taken;
    int    len;
    logic [1:0] op;
    logic [7:0] ch;
    alphabet = "ACGTNacgtn";
    taken = 0;
    while (taken < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          len = $urandom_range(0, 24);
          for (int i = 0; i < len; i++) begin
            ch = ($urandom_range(0, 9) == 0) ? 8'($urandom) : alphabet[$urandom_range(0, 9)];
            queue_item(OP_BASE, ch, 7'($urandom));
            taken++;
            if ($urandom_range(0, 7) == 0) begin
              queue_item(OP_READ, 8'($urandom), 7'($urandom_range(0, 85)));
              taken++;
            end
          end
          // drop the end marker now and then to run sequences together
          if ($urandom_range(0, 9) != 0) begin
            queue_item(OP_END, 8'($urandom), 7'($urandom));
            taken++;
          end
        end
        7, 8: begin
          queue_item(OP_READ, 8'($urandom), 7'($urandom));
          taken++;
        end
        default: begin
          op = 2'($urandom);
          queue_item(op, 8'($urandom), 7'($urandom));
          if (op != OP_IDLE) taken++;
        end
      endcase
    end
    // leave a sequence open across the next mode change
    for (int i = 0; i < 3; i++) queue_item(OP_BASE, alphabet[$urandom_range(0, 9)], '0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Whole-sequence mode: cleared counters, out-of-range read, all base
    // codes and both N cases, a non-empty and an empty sequence, an unused op.
    queue_item(OP_READ, 8'h00, 7'd0);
    queue_item(OP_READ, 8'h00, IDX_BASES);
    queue_item(OP_READ, 8'h00, 7'h7f);
    queue_item(OP_BASE, "A", 7'd0);
    queue_item(OP_BASE, "C", 7'd0);
    queue_item(OP_BASE, "G", 7'd0);
    queue_item(OP_BASE, "T", 7'd0);
    queue_item(OP_BASE, "N", 7'd0);
    queue_item(OP_BASE, "n", 7'd0);
    queue_item(OP_BASE, 8'h00, 7'd0);
    queue_item(OP_BASE, 8'hff, 7'd0);
    queue_item(OP_END, 8'h00, 7'd0);
    queue_item(OP_END, 8'h00, 7'd0);
    queue_item(OP_IDLE, 8'hff, 7'h7f);
    queue_item(OP_READ, 8'h00, IDX_SEG);
    queue_item(OP_READ, 8'h00, IDX_BASES);
    queue_item(OP_READ, 8'h00, IDX_TRI_BASE + 7'd7);  // ACG
    queue_item(OP_READ, 8'h00, IDX_DI_BASE);
    queue_item(OP_READ, 8'h00, IDX_TRI_END - 7'd1);

    // Split mode: N on an empty segment, N closing a segment, an end with
    // nothing open, an end closing a segment.
    write_split(1'b1);
    queue_item(OP_BASE, "N", 7'd0);
    queue_item(OP_BASE, "A", 7'd0);
    queue_item(OP_BASE, "C", 7'd0);
    queue_item(OP_BASE, "n", 7'd0);
    queue_item(OP_END, 8'h00, 7'd0);
    queue_item(OP_BASE, "G", 7'd0);
    queue_item(OP_END, 8'h00, 7'd0);
    queue_item(OP_READ, 8'h00, IDX_SEG);
    queue_item(OP_READ, 8'h00, IDX_BASES);

    // Random part, flipping the mode between phases.
    for (int p = 0; p < 4; p++) begin
      if (p != 0) write_split(!split_mode);
      queue_random_phase(PHASE_ITEMS);
    end

    settle();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
